// ===== src/rei_pkg.sv =====
package rei_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int RADIUS_WIDTH    = 31;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int WIDE_WIDTH      = 64;

   localparam logic [RADIUS_WIDTH-1:0] AXIS_MAX = 31'h7FFF_FFFF;
   localparam logic [COORD_WIDTH-1:0]  DIST_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_WIDTH-1:0]  DIST_MIN = 32'h8000_0000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_RADIUS_X = 3'd3,
      CSR_RADIUS_Y = 3'd4,
      CSR_RADIUS_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctl_type;

   // side data carried through the square root unit
   typedef struct packed {
      logic                  a_zero;
      logic                  miss;
      logic                  bneg;
      logic [WIDE_WIDTH-1:0] b_mag;
      logic [WIDE_WIDTH-1:0] a_sum;
   } sq_tag_type;

   // side data carried through the distance divider
   typedef struct packed {
      logic a_zero;
      logic miss;
      logic tneg;
   } dv_tag_type;

endpackage

// ===== src/rei_if.sv =====
interface rei_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [rei_pkg::COORD_WIDTH-1:0] origin_x;
   logic signed [rei_pkg::COORD_WIDTH-1:0] origin_y;
   logic signed [rei_pkg::COORD_WIDTH-1:0] origin_z;
   logic signed [rei_pkg::COORD_WIDTH-1:0] dir_x;
   logic signed [rei_pkg::COORD_WIDTH-1:0] dir_y;
   logic signed [rei_pkg::COORD_WIDTH-1:0] dir_z;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 output ready);
endinterface

interface rei_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   hit;
   logic signed [rei_pkg::COORD_WIDTH-1:0] distance;

   modport source (output valid, hit, distance, input ready);
   modport sink (input valid, hit, distance, output ready);
endinterface

// ===== src/rei_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Computes (in_mag << SH) / in_div; out_sat flags a quotient of 2^QW or more.
module rei_div #(
   parameter int NW = 32,
   parameter int DW = 31,
   parameter int QW = 31,
   parameter int SH = 16,
   parameter int TW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rei_pkg::stage_ctl_type in_ctl,
   input  logic [NW-1:0]          in_mag,
   input  logic [DW-1:0]          in_div,
   input  logic [TW-1:0]          in_tag,
   output logic                   out_valid,
   output logic [QW-1:0]          out_quo,
   output logic                   out_sat,
   output logic [TW-1:0]          out_tag
);

   localparam int CW  = NW + DW + QW;
   localparam int PRE = QW - SH;

   logic          valid_ff [QW+1];
   logic          valid_in [QW+1];
   logic [DW-1:0] rem_ff   [QW+1];
   logic [DW-1:0] rem_in   [QW+1];
   logic [QW-1:0] low_ff   [QW+1];
   logic [QW-1:0] low_in   [QW+1];
   logic [QW-1:0] quo_ff   [QW+1];
   logic [QW-1:0] quo_in   [QW+1];
   logic [DW-1:0] div_ff   [QW+1];
   logic [DW-1:0] div_in   [QW+1];
   logic          sat_ff   [QW+1];
   logic          sat_in   [QW+1];
   logic [TW-1:0] tag_ff   [QW+1];
   logic [TW-1:0] tag_in   [QW+1];

   always_comb begin
      logic [CW-1:0] cmp_mag;
      logic [CW-1:0] cmp_lim;
      logic [DW:0]   trial;
      logic          ge;
      cmp_mag = CW'(in_mag);
      cmp_lim = CW'(in_div) << PRE;
      // the high dividend bits already sit below the divisor unless saturated
      valid_in[0] = in_ctl.valid;
      rem_in[0]   = DW'(in_mag >> PRE);
      low_in[0]   = {in_mag[PRE-1:0], {SH{1'b0}}};
      quo_in[0]   = '0;
      div_in[0]   = in_div;
      sat_in[0]   = cmp_mag >= cmp_lim;
      tag_in[0]   = in_tag;
      for (int k = 1; k <= QW; k++) begin
         trial       = {rem_ff[k-1], low_ff[k-1][QW-1]};
         ge          = trial >= {1'b0, div_ff[k-1]};
         rem_in[k]   = ge ? DW'(trial - {1'b0, div_ff[k-1]}) : DW'(trial);
         low_in[k]   = low_ff[k-1] << 1;
         quo_in[k]   = {quo_ff[k-1][QW-2:0], ge};
         valid_in[k] = valid_ff[k-1];
         div_in[k]   = div_ff[k-1];
         sat_in[k]   = sat_ff[k-1];
         tag_in[k]   = tag_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '{default: 1'b0};
      end else if (in_ctl.advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.advance) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         quo_ff <= quo_in;
         div_ff <= div_in;
         sat_ff <= sat_in;
         tag_ff <= tag_in;
      end
   end

   assign out_valid = valid_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_sat   = sat_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

// ===== src/rei_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, most significant first.
module rei_sqrt #(
   parameter int DW = 96,
   parameter int RW = 48,
   parameter int TW = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rei_pkg::stage_ctl_type in_ctl,
   input  logic [DW-1:0]          in_rad,
   input  logic [TW-1:0]          in_tag,
   output logic                   out_valid,
   output logic [RW-1:0]          out_root,
   output logic [TW-1:0]          out_tag
);

   logic          valid_ff [RW+1];
   logic          valid_in [RW+1];
   logic [DW-1:0] rem_ff   [RW+1];
   logic [DW-1:0] rem_in   [RW+1];
   logic [RW-1:0] root_ff  [RW+1];
   logic [RW-1:0] root_in  [RW+1];
   logic [TW-1:0] tag_ff   [RW+1];
   logic [TW-1:0] tag_in   [RW+1];

   always_comb begin
      logic [DW-1:0] trial;
      logic          ge;
      int            i;
      valid_in[0] = in_ctl.valid;
      rem_in[0]   = in_rad;
      root_in[0]  = '0;
      tag_in[0]   = in_tag;
      for (int k = 1; k <= RW; k++) begin
         i = RW - k;
         // (2*root + 2^i) * 2^i, the growth of the square when bit i is set
         trial       = (DW'(root_ff[k-1]) << (i + 1)) | (DW'(1) << (2 * i));
         ge          = rem_ff[k-1] >= trial;
         rem_in[k]   = ge ? rem_ff[k-1] - trial : rem_ff[k-1];
         root_in[k]  = root_ff[k-1] | (RW'(ge) << i);
         valid_in[k] = valid_ff[k-1];
         tag_in[k]   = tag_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '{default: 1'b0};
      end else if (in_ctl.advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ctl.advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         tag_ff  <= tag_in;
      end
   end

   assign out_valid = valid_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_tag   = tag_ff[RW];

endmodule

// ===== src/ray_ellipsoid_intersect.sv =====
// Throughput: one ray per cycle; the whole pipeline holds while a response waits.
// Depth is set by the bit-serial stages of the axis dividers (31), the square
// root (32 + FRAC_BITS) and the distance divider (32).
// Reset: synchronous, clears all valid bits; center goes to 0, radii to 1.0.
module ray_ellipsoid_intersect #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   rei_req_if.sink                             req_bus,
   rei_rsp_if.source                           rsp_bus,
   input  logic                                csr_we,
   input  logic [rei_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rei_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int SQ_DW = 64 + 2 * FRAC_BITS;
   localparam int SQ_RW = 32 + FRAC_BITS;
   localparam int SQ_TW = $bits(rei_pkg::sq_tag_type);
   localparam int DV_TW = $bits(rei_pkg::dv_tag_type);
   localparam logic [30:0] RAD_ONE = 31'(1) << FRAC_BITS;

   typedef struct packed {
      logic [2:0][32:0] diff;
      logic [2:0][31:0] dir;
   } p1_type;

   typedef struct packed {
      logic [2:0][31:0] vmag;
      logic [2:0][31:0] umag;
      logic [2:0]       vneg;
      logic [2:0]       uneg;
   } p2_type;

   typedef struct packed {
      logic [2:0][61:0] uu;
      logic [2:0][61:0] vv;
      logic [2:0][61:0] uv;
      logic [2:0]       uvneg;
   } m1_type;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] v;
      logic [63:0] pos;
      logic [63:0] negs;
   } m2_type;

   typedef struct packed {
      logic [63:0] a;
      logic [63:0] v;
      logic [63:0] bm;
      logic        bneg;
      logic        a_zero;
   } m3_type;

   typedef struct packed {
      logic [63:0] bll;
      logic [63:0] blh;
      logic [63:0] bhh;
      logic [63:0] avll;
      logic [63:0] avlh;
      logic [63:0] avhl;
      logic [63:0] avhh;
      logic [63:0] a;
      logic [63:0] bm;
      logic        bneg;
      logic        a_zero;
   } m4_type;

   typedef struct packed {
      logic [127:0] bsq;
      logic [127:0] av;
      logic [63:0]  a;
      logic [63:0]  bm;
      logic         bneg;
      logic         a_zero;
   } m5_type;

   typedef struct packed {
      logic [127:0] t;
      logic [127:0] av;
      logic [63:0]  a;
      logic [63:0]  bm;
      logic         bneg;
      logic         a_zero;
   } m6_type;

   typedef struct packed {
      logic [SQ_DW-1:0]    d;
      rei_pkg::sq_tag_type tag;
   } m7_type;

   typedef struct packed {
      logic [63:0]         nm;
      logic [63:0]         a;
      rei_pkg::dv_tag_type tag;
   } n1_type;

   // configuration registers
   logic [31:0] cen_ff [3];
   logic [31:0] cen_in [3];
   logic [30:0] rad_ff [3];
   logic [30:0] rad_in [3];
   logic [2:0][30:0] rad_eff;

   logic en;

   logic p1_valid_ff, p2_valid_ff, m1_valid_ff, m2_valid_ff, m3_valid_ff;
   logic m4_valid_ff, m5_valid_ff, m6_valid_ff, m7_valid_ff, n1_valid_ff;
   logic out_valid_ff;
   logic m1_valid_in;

   p1_type p1_ff, p1_in;
   p2_type p2_ff, p2_in;
   m1_type m1_ff, m1_in;
   m2_type m2_ff, m2_in;
   m3_type m3_ff, m3_in;
   m4_type m4_ff, m4_in;
   m5_type m5_ff, m5_in;
   m6_type m6_ff, m6_in;
   m7_type m7_ff, m7_in;
   n1_type n1_ff, n1_in;

   logic        out_hit_ff, out_hit_in;
   logic [31:0] out_dist_ff, out_dist_in;

   logic [2:0][31:0] org;
   logic [2:0][31:0] dir;

   logic [2:0]       u_valid, v_valid;
   logic [2:0][30:0] u_quo, v_quo;
   logic [2:0]       u_sat, v_sat;
   logic [2:0]       u_sign, v_sign;

   rei_pkg::stage_ctl_type p2_ctl, m7_ctl, n1_ctl;

   logic                sq_valid;
   logic [SQ_RW-1:0]    sq_root;
   rei_pkg::sq_tag_type sq_tag;

   logic                dv_valid;
   logic [31:0]         dv_quo;
   logic                dv_sat;
   rei_pkg::dv_tag_type dv_tag;

   // the pipeline moves as a whole unless a response word is held
   assign en            = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   // configuration
   always_comb begin
      cen_in = cen_ff;
      rad_in = rad_ff;
      if (csr_we) begin
         unique case (rei_pkg::csr_index_type'(csr_index))
            rei_pkg::CSR_CENTER_X: cen_in[0] = csr_wdata;
            rei_pkg::CSR_CENTER_Y: cen_in[1] = csr_wdata;
            rei_pkg::CSR_CENTER_Z: cen_in[2] = csr_wdata;
            rei_pkg::CSR_RADIUS_X: rad_in[0] = csr_wdata[30:0];
            rei_pkg::CSR_RADIUS_Y: rad_in[1] = csr_wdata[30:0];
            rei_pkg::CSR_RADIUS_Z: rad_in[2] = csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cen_ff <= '{default: '0};
         rad_ff <= '{default: RAD_ONE};
      end else begin
         cen_ff <= cen_in;
         rad_ff <= rad_in;
      end
   end

   // a zero radius acts as one LSB
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         rad_eff[a] = (rad_ff[a] == '0) ? 31'd1 : rad_ff[a];
      end
   end

   // P1: shift origin by center
   always_comb begin
      org[0] = req_bus.origin_x;
      org[1] = req_bus.origin_y;
      org[2] = req_bus.origin_z;
      dir[0] = req_bus.dir_x;
      dir[1] = req_bus.dir_y;
      dir[2] = req_bus.dir_z;
      for (int a = 0; a < 3; a++) begin
         p1_in.diff[a] = {org[a][31], org[a]} - {cen_ff[a][31], cen_ff[a]};
         p1_in.dir[a]  = dir[a];
      end
   end

   // P2: split into sign and magnitude
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         p2_in.vneg[a] = p1_ff.diff[a][32];
         p2_in.vmag[a] = p1_ff.diff[a][32] ? 32'(-p1_ff.diff[a]) : p1_ff.diff[a][31:0];
         p2_in.uneg[a] = p1_ff.dir[a][31];
         p2_in.umag[a] = p1_ff.dir[a][31] ? -p1_ff.dir[a] : p1_ff.dir[a];
      end
   end

   assign p2_ctl = '{advance: en, valid: p2_valid_ff};

   for (genvar g = 0; g < 3; g++) begin : g_axis
      rei_div #(
         .NW (32),
         .DW (rei_pkg::RADIUS_WIDTH),
         .QW (rei_pkg::RADIUS_WIDTH),
         .SH (FRAC_BITS),
         .TW (1)
      ) u_div_dir (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (p2_ctl),
         .in_mag    (p2_ff.umag[g]),
         .in_div    (rad_eff[g]),
         .in_tag    (p2_ff.uneg[g]),
         .out_valid (u_valid[g]),
         .out_quo   (u_quo[g]),
         .out_sat   (u_sat[g]),
         .out_tag   (u_sign[g])
      );

      rei_div #(
         .NW (32),
         .DW (rei_pkg::RADIUS_WIDTH),
         .QW (rei_pkg::RADIUS_WIDTH),
         .SH (FRAC_BITS),
         .TW (1)
      ) u_div_org (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (p2_ctl),
         .in_mag    (p2_ff.vmag[g]),
         .in_div    (rad_eff[g]),
         .in_tag    (p2_ff.vneg[g]),
         .out_valid (v_valid[g]),
         .out_quo   (v_quo[g]),
         .out_sat   (v_sat[g]),
         .out_tag   (v_sign[g])
      );
   end

   // M1: squares and cross products of the scaled axes
   assign m1_valid_in = &{u_valid, v_valid};

   always_comb begin
      logic [30:0] u;
      logic [30:0] v;
      u = '0;
      v = '0;
      for (int a = 0; a < 3; a++) begin
         u              = u_sat[a] ? rei_pkg::AXIS_MAX : u_quo[a];
         v              = v_sat[a] ? rei_pkg::AXIS_MAX : v_quo[a];
         m1_in.uu[a]    = 62'(u) * 62'(u);
         m1_in.vv[a]    = 62'(v) * 62'(v);
         m1_in.uv[a]    = 62'(u) * 62'(v);
         m1_in.uvneg[a] = u_sign[a] ^ v_sign[a];
      end
   end

   // M2: sums
   always_comb begin
      m2_in = '0;
      for (int a = 0; a < 3; a++) begin
         m2_in.a = m2_in.a + 64'(m1_ff.uu[a]);
         m2_in.v = m2_in.v + 64'(m1_ff.vv[a]);
         if (m1_ff.uvneg[a]) begin
            m2_in.negs = m2_in.negs + 64'(m1_ff.uv[a]);
         end else begin
            m2_in.pos = m2_in.pos + 64'(m1_ff.uv[a]);
         end
      end
   end

   // M3: signed B as sign and magnitude
   always_comb begin
      m3_in.a      = m2_ff.a;
      m3_in.v      = m2_ff.v;
      m3_in.bneg   = m2_ff.negs > m2_ff.pos;
      m3_in.bm     = m3_in.bneg ? m2_ff.negs - m2_ff.pos : m2_ff.pos - m2_ff.negs;
      m3_in.a_zero = m2_ff.a == '0;
   end

   // M4: 32x32 partial products of B*B and A*V
   always_comb begin
      m4_in.bll    = 64'(m3_ff.bm[31:0])  * 64'(m3_ff.bm[31:0]);
      m4_in.blh    = 64'(m3_ff.bm[31:0])  * 64'(m3_ff.bm[63:32]);
      m4_in.bhh    = 64'(m3_ff.bm[63:32]) * 64'(m3_ff.bm[63:32]);
      m4_in.avll   = 64'(m3_ff.a[31:0])   * 64'(m3_ff.v[31:0]);
      m4_in.avlh   = 64'(m3_ff.a[31:0])   * 64'(m3_ff.v[63:32]);
      m4_in.avhl   = 64'(m3_ff.a[63:32])  * 64'(m3_ff.v[31:0]);
      m4_in.avhh   = 64'(m3_ff.a[63:32])  * 64'(m3_ff.v[63:32]);
      m4_in.a      = m3_ff.a;
      m4_in.bm     = m3_ff.bm;
      m4_in.bneg   = m3_ff.bneg;
      m4_in.a_zero = m3_ff.a_zero;
   end

   // M5: assemble the 128-bit products
   always_comb begin
      m5_in.bsq    = {m4_ff.bhh, m4_ff.bll} + (128'(m4_ff.blh) << 33);
      m5_in.av     = {m4_ff.avhh, m4_ff.avll} + (128'(m4_ff.avlh) << 32)
                   + (128'(m4_ff.avhl) << 32);
      m5_in.a      = m4_ff.a;
      m5_in.bm     = m4_ff.bm;
      m5_in.bneg   = m4_ff.bneg;
      m5_in.a_zero = m4_ff.a_zero;
   end

   // M6: B^2 + A * 1.0^2
   always_comb begin
      m6_in.t      = m5_ff.bsq + (128'(m5_ff.a) << (2 * FRAC_BITS));
      m6_in.av     = m5_ff.av;
      m6_in.a      = m5_ff.a;
      m6_in.bm     = m5_ff.bm;
      m6_in.bneg   = m5_ff.bneg;
      m6_in.a_zero = m5_ff.a_zero;
   end

   // M7: discriminant; it never exceeds A * 1.0^2 when non-negative
   always_comb begin
      m7_in.d          = SQ_DW'(m6_ff.t - m6_ff.av);
      m7_in.tag.miss   = m6_ff.t < m6_ff.av;
      m7_in.tag.a_zero = m6_ff.a_zero;
      m7_in.tag.bneg   = m6_ff.bneg;
      m7_in.tag.b_mag  = m6_ff.bm;
      m7_in.tag.a_sum  = m6_ff.a;
   end

   assign m7_ctl = '{advance: en, valid: m7_valid_ff};

   rei_sqrt #(
      .DW (SQ_DW),
      .RW (SQ_RW),
      .TW (SQ_TW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (m7_ctl),
      .in_rad    (m7_ff.d),
      .in_tag    (m7_ff.tag),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   // N1: numerator -(B + S) as sign and magnitude
   always_comb begin
      logic [63:0] s;
      logic [64:0] bms;
      s   = 64'(sq_root);
      bms = {1'b0, sq_tag.b_mag} - {1'b0, s};
      if (!sq_tag.bneg) begin
         n1_in.tag.tneg = 1'b1;
         n1_in.nm       = sq_tag.b_mag + s;
      end else if (!bms[64]) begin
         n1_in.tag.tneg = 1'b0;
         n1_in.nm       = bms[63:0];
      end else begin
         n1_in.tag.tneg = 1'b1;
         n1_in.nm       = s - sq_tag.b_mag;
      end
      n1_in.a          = sq_tag.a_sum;
      n1_in.tag.a_zero = sq_tag.a_zero;
      n1_in.tag.miss   = sq_tag.miss;
   end

   assign n1_ctl = '{advance: en, valid: n1_valid_ff};

   rei_div #(
      .NW (rei_pkg::WIDE_WIDTH),
      .DW (rei_pkg::WIDE_WIDTH),
      .QW (rei_pkg::COORD_WIDTH),
      .SH (FRAC_BITS),
      .TW (DV_TW)
   ) u_div_dist (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (n1_ctl),
      .in_mag    (n1_ff.nm),
      .in_div    (n1_ff.a),
      .in_tag    (n1_ff.tag),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_sat   (dv_sat),
      .out_tag   (dv_tag)
   );

   // output: clamp to the signed 32-bit range
   always_comb begin
      out_hit_in  = 1'b0;
      out_dist_in = '0;
      if (!dv_tag.a_zero && !dv_tag.miss) begin
         out_hit_in = 1'b1;
         if (dv_tag.tneg) begin
            if (dv_sat || dv_quo >= rei_pkg::DIST_MIN) begin
               out_dist_in = rei_pkg::DIST_MIN;
            end else begin
               out_dist_in = -dv_quo;
            end
         end else begin
            if (dv_sat || dv_quo[31]) begin
               out_dist_in = rei_pkg::DIST_MAX;
            end else begin
               out_dist_in = dv_quo;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         m4_valid_ff  <= 1'b0;
         m5_valid_ff  <= 1'b0;
         m6_valid_ff  <= 1'b0;
         m7_valid_ff  <= 1'b0;
         n1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff  <= req_bus.valid;
         p2_valid_ff  <= p1_valid_ff;
         m1_valid_ff  <= m1_valid_in;
         m2_valid_ff  <= m1_valid_ff;
         m3_valid_ff  <= m2_valid_ff;
         m4_valid_ff  <= m3_valid_ff;
         m5_valid_ff  <= m4_valid_ff;
         m6_valid_ff  <= m5_valid_ff;
         m7_valid_ff  <= m6_valid_ff;
         n1_valid_ff  <= sq_valid;
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff       <= p1_in;
         p2_ff       <= p2_in;
         m1_ff       <= m1_in;
         m2_ff       <= m2_in;
         m3_ff       <= m3_in;
         m4_ff       <= m4_in;
         m5_ff       <= m5_in;
         m6_ff       <= m6_in;
         m7_ff       <= m7_in;
         n1_ff       <= n1_in;
         out_hit_ff  <= out_hit_in;
         out_dist_ff <= out_dist_in;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.hit      = out_hit_ff;
   assign rsp_bus.distance = out_dist_ff;

endmodule

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int LATENCY = 109 + FRAC;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [rei_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 3'd7;
   localparam logic [63:0] AXIS_LIM = 64'h7FFF_FFFF;

   typedef struct packed {
      logic signed [rei_pkg::COORD_WIDTH-1:0] origin_x;
      logic signed [rei_pkg::COORD_WIDTH-1:0] origin_y;
      logic signed [rei_pkg::COORD_WIDTH-1:0] origin_z;
      logic signed [rei_pkg::COORD_WIDTH-1:0] dir_x;
      logic signed [rei_pkg::COORD_WIDTH-1:0] dir_y;
      logic signed [rei_pkg::COORD_WIDTH-1:0] dir_z;
   } ray_type;

   typedef struct packed {
      logic                            hit;
      logic [rei_pkg::COORD_WIDTH-1:0] distance;
   } crossing_type;

   typedef struct {
      ray_type      ray;
      bit           typed;
      crossing_type want;
   } ray_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [rei_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [rei_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   rei_req_if req_bus ();
   rei_rsp_if rsp_bus ();

   ray_ellipsoid_intersect #(.FRAC_BITS(FRAC)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the ellipsoid registers
   logic signed [rei_pkg::COORD_WIDTH-1:0] center_sh [3];
   logic [rei_pkg::RADIUS_WIDTH-1:0]       radius_sh [3];

   crossing_type crossings_due [$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  hold_rsp = 0;
   bit  calm = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] scale_axis(longint signed val,
                                              logic [rei_pkg::RADIUS_WIDTH-1:0] r,
                                              output bit neg);
      logic [63:0] mag, rr, q;
      neg = val < 0;
      mag = neg ? -val : val;
      rr = (r == 0) ? 64'd1 : {33'd0, r};
      q = (mag << FRAC) / rr;
      return (q > AXIS_LIM) ? AXIS_LIM : q;
   endfunction

   function automatic crossing_type trace_ray(ray_type r);
      logic signed [rei_pkg::COORD_WIDTH-1:0] org [3], dir [3];
      logic [63:0] u, v, a_sum, v_sum, pos, negs, b_mag, root, nm, cand;
      logic [127:0] disc, av, q;
      bit un, vn, bneg, tneg;
      crossing_type res;
      org = '{r.origin_x, r.origin_y, r.origin_z};
      dir = '{r.dir_x, r.dir_y, r.dir_z};
      a_sum = 0; v_sum = 0; pos = 0; negs = 0;
      for (int i = 0; i < 3; i++) begin
         u = scale_axis(longint'(dir[i]), radius_sh[i], un);
         v = scale_axis(longint'(org[i]) - longint'(center_sh[i]), radius_sh[i], vn);
         a_sum += u * u;
         v_sum += v * v;
         if (un != vn) negs += u * v;
         else pos += u * v;
      end
      res = '0;
      if (a_sum == 0) return res;
      bneg = negs > pos;
      b_mag = bneg ? negs - pos : pos - negs;
      disc = {64'd0, b_mag} * {64'd0, b_mag} + ({64'd0, a_sum} << (2 * FRAC));
      av = {64'd0, a_sum} * {64'd0, v_sum};
      if (disc < av) return res;
      disc -= av;
      root = 0;
      for (int i = 55; i >= 0; i--) begin
         cand = root | (64'd1 << i);
         if ({64'd0, cand} * {64'd0, cand} <= disc) root = cand;
      end
      if (!bneg) begin
         tneg = 1; nm = b_mag + root;
      end else if (b_mag >= root) begin
         tneg = 0; nm = b_mag - root;
      end else begin
         tneg = 1; nm = root - b_mag;
      end
      q = ({64'd0, nm} << FRAC) / {64'd0, a_sum};
      if (tneg) begin
         if (q > 128'h8000_0000) q = 128'h8000_0000;
         res.distance = -q[31:0];
      end else begin
         if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
         res.distance = q[31:0];
      end
      res.hit = 1;
      return res;
   endfunction

   task automatic write_reg(logic [rei_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [rei_pkg::CSR_DATA_WIDTH-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         rei_pkg::CSR_CENTER_X: center_sh[0] = val;
         rei_pkg::CSR_CENTER_Y: center_sh[1] = val;
         rei_pkg::CSR_CENTER_Z: center_sh[2] = val;
         rei_pkg::CSR_RADIUS_X: radius_sh[0] = val[rei_pkg::RADIUS_WIDTH-1:0];
         rei_pkg::CSR_RADIUS_Y: radius_sh[1] = val[rei_pkg::RADIUS_WIDTH-1:0];
         rei_pkg::CSR_RADIUS_Z: radius_sh[2] = val[rei_pkg::RADIUS_WIDTH-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic load_ellipsoid(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                 logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
      write_reg(rei_pkg::CSR_CENTER_X, cx);
      write_reg(rei_pkg::CSR_CENTER_Y, cy);
      write_reg(rei_pkg::CSR_CENTER_Z, cz);
      write_reg(rei_pkg::CSR_RADIUS_X, rx);
      write_reg(rei_pkg::CSR_RADIUS_Y, ry);
      write_reg(rei_pkg::CSR_RADIUS_Z, rz);
      csr_we <= 0;
      @(posedge clock);
   endtask

   // offer one word, hold until accepted, then maybe drop valid for a gap
   task automatic send_ray(ray_type r, bit typed, crossing_type want);
      int gap;
      req_bus.valid <= 1;
      req_bus.origin_x <= r.origin_x;
      req_bus.origin_y <= r.origin_y;
      req_bus.origin_z <= r.origin_z;
      req_bus.dir_x <= r.dir_x;
      req_bus.dir_y <= r.dir_y;
      req_bus.dir_z <= r.dir_z;
      do @(posedge clock); while (!req_bus.ready);
      crossings_due.push_back(typed ? want : trace_ray(r));
      gap = 0;
      if (!calm && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic ray_type random_ray();
      ray_type r;
      logic signed [31:0] k [3];
      int sh;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(0, 3) != 0) begin
         // aim roughly at the center from a random offset
         for (int i = 0; i < 3; i++)
            k[i] = $signed($urandom) >>> $urandom_range(0, 31);
         sh = $urandom_range(0, 12);
         r.origin_x = center_sh[0] + k[0];
         r.origin_y = center_sh[1] + k[1];
         r.origin_z = center_sh[2] + k[2];
         r.dir_x = (-k[0] >>> sh) + $signed($urandom_range(0, 255)) - 128;
         r.dir_y = (-k[1] >>> sh) + $signed($urandom_range(0, 255)) - 128;
         r.dir_z = (-k[2] >>> sh) + $signed($urandom_range(0, 255)) - 128;
      end
      return r;
   endfunction

   task automatic drain();
      while (crossings_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_bus.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 0;
            stall = 0;
            while (stall < 400) begin
               @(posedge clock);
               stall++;
            end
            hold_rsp = 0;
            rsp_bus.ready <= 1;
         end else if (calm) begin
            rsp_bus.ready <= 1;
         end else if ($urandom_range(0, 199) == 0) begin
            rsp_bus.ready <= 0;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // check responses against the oldest pending crossing
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (crossings_due.size() == 0) begin
            $display("%0t: unexpected word hit=%0b distance=%h", $time,
                     rsp_bus.hit, rsp_bus.distance);
            errors++;
         end else begin
            want = crossings_due.pop_front();
            if (rsp_bus.hit !== want.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_bus.hit);
               errors++;
            end
            if (rsp_bus.distance !== want.distance) begin
               $display("%0t: distance expected %h actual %h", $time,
                        want.distance, rsp_bus.distance);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (!req_bus.valid && crossings_due.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress", $time);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      ray_row_type rows [$];
      localparam logic signed [31:0] ONE = 32'sh0001_0000;
      localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
      localparam logic signed [31:0] SMIN = 32'sh8000_0000;
      reset = 1;
      csr_we = 0;
      csr_index = rei_pkg::CSR_CENTER_X;
      csr_wdata = 0;
      req_bus.valid = 0;
      {req_bus.origin_x, req_bus.origin_y, req_bus.origin_z} = '0;
      {req_bus.dir_x, req_bus.dir_y, req_bus.dir_z} = '0;
      center_sh = '{0, 0, 0};
      radius_sh = '{31'h10000, 31'h10000, 31'h10000};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // unit sphere at origin after reset
      rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0}});
      rows.push_back('{'{ONE, 0, 0, 0, 0, 0}, 1, '{0, 0}});
      rows.push_back('{'{-2 * ONE, 0, 0, ONE, 0, 0}, 1, '{1, 32'h0001_0000}});
      rows.push_back('{'{0, 5 * ONE, 0, ONE, 0, 0}, 1, '{0, 0}});
      rows.push_back('{'{0, 0, 0, ONE, 0, 0}, 1, '{1, 32'hFFFF_0000}});
      rows.push_back('{'{-2 * ONE, ONE, 0, ONE, 0, 0}, 1, '{1, 32'h0002_0000}});
      rows.push_back('{'{2 * ONE, 0, 0, ONE, 0, 0}, 1, '{1, 32'hFFFD_0000}});
      rows.push_back('{'{SMAX, SMAX, SMAX, SMAX, SMAX, SMAX}, 0, '{0, 0}});
      rows.push_back('{'{SMIN, SMIN, SMIN, SMIN, SMIN, SMIN}, 0, '{0, 0}});
      rows.push_back('{'{SMIN, SMAX, 0, SMAX, SMIN, 1}, 0, '{0, 0}});
      rows.push_back('{'{0, 0, 0, 1, 0, 0}, 0, '{0, 0}});
      rows.push_back('{'{-30000 * ONE, 0, 0, 1, 0, 0}, 0, '{0, 0}});
      rows.push_back('{'{30000 * ONE, 0, 0, 1, 0, 0}, 0, '{0, 0}});
      rows.push_back('{'{0, 0, -3 * ONE, 0, -1, ONE}, 0, '{0, 0}});
      foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].want);
      req_bus.valid <= 0;
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_ellipsoid(3 * ONE, -ONE, 0, 2 * ONE, ONE / 2, 5 * ONE);
            1: load_ellipsoid(SMAX, SMIN, SMAX, 1, 1, 1);
            2: load_ellipsoid(SMIN, SMAX, SMIN, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
            3: load_ellipsoid(0, 0, 0, 0, 0, 0);
            4: begin
               write_reg(CSR_UNUSED, 32'hDEAD_BEEF);
               load_ellipsoid($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            default: load_ellipsoid(-7 * ONE, 100 * ONE, ONE, 40 * ONE, 3 * ONE, 64 * ONE);
         endcase
         for (int n = 0; n < 325; n++) begin
            if (n % 80 == 0) calm = ($urandom_range(0, 2) == 0);
            if (phase == 2 && n == 40) begin
               calm = 1;
               hold_rsp = 1;
            end
            send_ray(random_ray(), 0, '{0, 0});
         end
         calm = 0;
         req_bus.valid <= 0;
         drain();
      end

      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
